// ===== rtl/core/ssp_pkg.sv =====
`timescale 1ns / 1ps

package ssp_pkg;

  localparam int VALUE_BITS = 64;
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIGN,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS,
    PH_LETTER,
    PH_SUF_I,
    PH_SUF_END
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef enum logic {
    BK_PARSE,
    BK_SCALE
  } bk_mode_t;

  // one classified byte
  typedef struct packed {
    logic       is_end;
    logic       is_space;
    logic       is_plus;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_x;
    logic       is_i;
    logic       is_big_b;
    logic [3:0] power;
  } token_t;

endpackage

// ===== rtl/core/ssp_front.sv =====
`timescale 1ns / 1ps

module ssp_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_char_code,
  input  logic            q_full,
  output logic            q_push,
  output ssp_pkg::token_t q_push_tok
);
  import ssp_pkg::*;

  function automatic token_t classify(input logic [7:0] c);
    token_t t;
    t          = '0;
    t.is_end   = (c == 8'h00);
    t.is_space = c inside {8'h20, [8'h09:8'h0D]};
    t.is_plus  = (c == 8'h2B);
    t.is_x     = (c == 8'h78) || (c == 8'h58);
    t.is_i     = (c == 8'h69);
    t.is_big_b = (c == 8'h42);
    if (c inside {[8'h30:8'h39]}) begin
      t.is_hex  = 1'b1;
      t.hex_val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      t.is_hex  = 1'b1;
      t.hex_val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      t.is_hex  = 1'b1;
      t.hex_val = 4'(c - 8'h37);
    end
    case (c)
      8'h4B, 8'h6B: t.power = 4'd1;  // K k
      8'h4D, 8'h6D: t.power = 4'd2;  // M m
      8'h47, 8'h67: t.power = 4'd3;  // G g
      8'h54, 8'h74: t.power = 4'd4;  // T t
      8'h50, 8'h70: t.power = 4'd5;  // P p
      8'h45, 8'h65: t.power = 4'd6;  // E e
      8'h5A:        t.power = 4'd7;  // Z
      8'h59:        t.power = 4'd8;  // Y
      default:      t.power = 4'd0;
    endcase
    return t;
  endfunction

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign q_push_tok = classify(in_char_code);

endmodule

// ===== rtl/core/ssp_queue.sv =====
`timescale 1ns / 1ps

module ssp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssp_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ssp_pkg::token_t pop_tok
);
  import ssp_pkg::*;

  token_t                 slot_r [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_BITS'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_tok = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ===== rtl/core/ssp_back.sv =====
`timescale 1ns / 1ps

module ssp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  ssp_pkg::token_t              q_tok,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ssp_pkg::VALUE_BITS-1:0] out_size_value,
  output logic [1:0]                   out_status
);
  import ssp_pkg::*;

  bk_mode_t   mode_r, mode_nxt;
  phase_t     phase_r, phase_nxt;
  radix_t     radix_r, radix_nxt;
  value_t     acc_r, acc_nxt;
  logic       seen_r, seen_nxt;
  logic       dovf_r, dovf_nxt;
  logic [3:0] power_r, power_nxt;
  logic       thou_r, thou_nxt;
  logic       syn_r, syn_nxt;
  logic [1:0] stat_r, stat_nxt;

  logic       out_valid_r, out_valid_nxt;
  value_t     out_value_r;
  logic [1:0] out_status_r;

  // decoded action of the popped byte
  phase_t     dec_phase;
  radix_t     dec_radix;
  logic       dec_add, dec_seen, dec_letter, dec_thou, dec_err;

  logic                  take_tok, take_end, deliver, out_free, bad_end;
  logic [VALUE_BITS+3:0] dig_ext, dig_mul, dig_sum;
  logic                  dig_ovf;
  logic [VALUE_BITS+9:0] sc_ext, sc_prod;
  logic                  sc_ovf;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (mode_r == BK_PARSE) && q_valid;
  assign take_tok = q_pop && !q_tok.is_end;
  assign take_end = q_pop && q_tok.is_end;
  assign deliver  = (mode_r == BK_SCALE) && (power_r == 4'd0) && out_free;
  assign bad_end  = syn_r || !seen_r || dovf_r || (phase_r == PH_HEXPFX)
                    || (phase_r == PH_SUF_I);

  // byte decode against the current phase
  always_comb begin
    dec_phase  = phase_r;
    dec_radix  = radix_r;
    dec_add    = 1'b0;
    dec_seen   = 1'b0;
    dec_letter = 1'b0;
    dec_thou   = 1'b0;
    dec_err    = 1'b0;
    if (!syn_r) begin
      case (phase_r)
        PH_IDLE, PH_SIGN: begin
          if (phase_r == PH_IDLE && q_tok.is_space) begin
            dec_phase = phase_r;
          end else if (phase_r == PH_IDLE && q_tok.is_plus) begin
            dec_phase = PH_SIGN;
          end else if (q_tok.is_hex && q_tok.hex_val == 4'd0) begin
            dec_seen  = 1'b1;
            dec_phase = PH_ZERO;
          end else if (q_tok.is_hex && q_tok.hex_val <= 4'd9) begin
            dec_radix = RADIX_DEC;
            dec_add   = 1'b1;
            dec_phase = PH_DIGITS;
          end else begin
            dec_err = 1'b1;
          end
        end
        PH_ZERO: begin
          if (q_tok.is_x) begin
            dec_phase = PH_HEXPFX;
          end else if (q_tok.is_hex && q_tok.hex_val <= 4'd7) begin
            dec_radix = RADIX_OCT;
            dec_add   = 1'b1;
            dec_phase = PH_DIGITS;
          end else begin
            dec_letter = 1'b1;
          end
        end
        PH_HEXPFX: begin
          if (q_tok.is_hex) begin
            dec_radix = RADIX_HEX;
            dec_add   = 1'b1;
            dec_phase = PH_DIGITS;
          end else begin
            dec_err = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (q_tok.is_hex && (radix_r == RADIX_HEX
              || (radix_r == RADIX_OCT && q_tok.hex_val <= 4'd7)
              || (radix_r == RADIX_DEC && q_tok.hex_val <= 4'd9))) begin
            dec_add = 1'b1;
          end else begin
            dec_letter = 1'b1;
          end
        end
        PH_LETTER: begin
          if (q_tok.is_i) begin
            dec_phase = PH_SUF_I;
          end else if (q_tok.is_big_b) begin
            dec_thou  = 1'b1;
            dec_phase = PH_SUF_END;
          end else begin
            dec_err = 1'b1;
          end
        end
        PH_SUF_I: begin
          if (q_tok.is_big_b) begin
            dec_phase = PH_SUF_END;
          end else begin
            dec_err = 1'b1;
          end
        end
        default: dec_err = 1'b1;
      endcase
      if (dec_letter) begin
        if (q_tok.power == 4'd0) begin
          dec_err = 1'b1;
        end else begin
          dec_phase = PH_LETTER;
        end
      end
    end
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    case (mode_r)
      BK_PARSE: begin
        if (take_end) begin
          mode_nxt = BK_SCALE;
        end else if (take_tok) begin
          phase_nxt = dec_phase;
        end
      end
      BK_SCALE: begin
        if (deliver) begin
          mode_nxt  = BK_PARSE;
          phase_nxt = PH_IDLE;
        end
      end
      default: mode_nxt = BK_PARSE;
    endcase
  end

  // digit step: acc * radix + digit, overflow when the top bits are set
  always_comb begin
    dig_ext = {4'b0, acc_r};
    case (dec_radix)
      RADIX_OCT: dig_mul = dig_ext << 3;
      RADIX_HEX: dig_mul = dig_ext << 4;
      default:   dig_mul = (dig_ext << 3) + (dig_ext << 1);
    endcase
    dig_sum = dig_mul + {{VALUE_BITS{1'b0}}, q_tok.hex_val};
    dig_ovf = |dig_sum[VALUE_BITS+3:VALUE_BITS];
  end

  // scale step: times 1024 or 1000
  always_comb begin
    sc_ext = {10'b0, acc_r};
    if (thou_r) begin
      sc_prod = (sc_ext << 10) - (sc_ext << 4) - (sc_ext << 3);
    end else begin
      sc_prod = sc_ext << 10;
    end
    sc_ovf = |sc_prod[VALUE_BITS+9:VALUE_BITS];
  end

  // datapath
  always_comb begin
    radix_nxt     = radix_r;
    acc_nxt       = acc_r;
    seen_nxt      = seen_r;
    dovf_nxt      = dovf_r;
    power_nxt     = power_r;
    thou_nxt      = thou_r;
    syn_nxt       = syn_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (take_tok) begin
      radix_nxt = dec_radix;
      seen_nxt  = seen_r || dec_add || dec_seen;
      syn_nxt   = syn_r || dec_err;
      thou_nxt  = thou_r || dec_thou;
      if (dec_letter && !dec_err) begin
        power_nxt = q_tok.power;
      end
      if (dec_add && !dovf_r) begin
        if (dig_ovf) begin
          dovf_nxt = 1'b1;
        end else begin
          acc_nxt = dig_sum[VALUE_BITS-1:0];
        end
      end
    end else if (take_end) begin
      if (bad_end) begin
        acc_nxt   = '0;
        stat_nxt  = STAT_INVALID;
        power_nxt = 4'd0;
      end else begin
        stat_nxt = STAT_OK;
        if (!(phase_r == PH_LETTER || phase_r == PH_SUF_END)) begin
          power_nxt = 4'd0;
        end
      end
    end else if (mode_r == BK_SCALE) begin
      if (power_r != 4'd0) begin
        if (sc_ovf) begin
          stat_nxt  = STAT_OVERFLOW;
          power_nxt = 4'd0;
        end else begin
          acc_nxt   = sc_prod[VALUE_BITS-1:0];
          power_nxt = power_r - 4'd1;
        end
      end else if (deliver) begin
        out_valid_nxt = 1'b1;
        radix_nxt     = RADIX_DEC;
        acc_nxt       = '0;
        seen_nxt      = 1'b0;
        dovf_nxt      = 1'b0;
        thou_nxt      = 1'b0;
        syn_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= BK_PARSE;
      phase_r     <= PH_IDLE;
      radix_r     <= RADIX_DEC;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      dovf_r      <= 1'b0;
      power_r     <= 4'd0;
      thou_r      <= 1'b0;
      syn_r       <= 1'b0;
      stat_r      <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      radix_r     <= radix_nxt;
      acc_r       <= acc_nxt;
      seen_r      <= seen_nxt;
      dovf_r      <= dovf_nxt;
      power_r     <= power_nxt;
      thou_r      <= thou_nxt;
      syn_r       <= syn_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_value_r  <= acc_r;
      out_status_r <= stat_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_size_value = out_value_r;
  assign out_status     = out_status_r;

endmodule

// ===== rtl/core/size_string_parser.sv =====
`timescale 1ns / 1ps
// Timing: after the zero byte is accepted, the back end applies n = suffix power (0..8, less
//   on overflow) scaling multiplies, then registers the result onto out_valid.
// Throughput: one request per cycle while the two-entry queue has room; the terminator holds
//   the back end through its scaling, one multiply per cycle, and until the output is free.
// Reset: rst_n is synchronous, active low; it empties the queue and the output register
//   and returns the parser to its idle phase with a zero accumulator.

module size_string_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_code,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ssp_pkg::VALUE_BITS-1:0] out_size_value,
  output logic [1:0]                     out_status
);
  import ssp_pkg::*;

  // front to queue
  logic   q_push, q_full;
  token_t q_push_tok;
  // queue to back end
  logic   q_pop, q_valid;
  token_t q_pop_tok;

  // Front end: classify each byte of the request stream into a token (digit value,
  // whitespace, plus sign, x, i, B, suffix power, terminator) and push it.
  ssp_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_tok   (q_push_tok)
  );

  // Short queue decouples the byte stream from the scaling back end, so the
  // input keeps flowing while the back end spends cycles on a terminator.
  ssp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (q_push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_tok  (q_pop_tok)
  );

  // Back end: run the parse phases, accumulate digits with overflow tracking,
  // then on the terminator apply the suffix one multiply per cycle and hand
  // the result to the output register.
  ssp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_tok          (q_pop_tok),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_size_value (out_size_value),
    .out_status     (out_status)
  );

endmodule

// ===== rtl/core/ssp_checker.sv =====
`timescale 1ns / 1ps

module ssp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     in_char_code,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ssp_pkg::VALUE_BITS-1:0] out_size_value,
  input logic [1:0]                     out_status
);
  import ssp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_size_value) && $stable(out_status))
    else $error("stalled result changed");

  // an invalid result always carries value zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_INVALID |-> out_size_value == '0)
    else $error("invalid result with nonzero value");

  // reset clears the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_char_code))
    else $error("stalled request changed");

endmodule

bind size_string_parser ssp_checker u_ssp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_char_code   (in_char_code),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_size_value (out_size_value),
  .out_status     (out_status)
);

// ===== sim/size_string_parser_tb.sv =====
`timescale 1ns / 1ps

module size_string_parser_tb;
  import ssp_pkg::*;

  localparam int     CLK_HALF    = 6;        // 12 ns period
  localparam int     RESET_CYCLES = 12;
  localparam int     RANDOM_BYTES = 900;
  localparam int     CYCLE_LIMIT = 500000;   // far above the slowest legal run
  localparam int     DRAIN_CYCLES = 40;      // margin for the scale steps of a terminator
  localparam int     HOLD_CYCLES = 400;      // long receiver hold-off to fill the queue
  localparam value_t SIZE_MAX = '1;

  typedef struct {
    value_t     size_value;
    logic [1:0] status;
  } size_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [7:0]   in_char_code = 8'h00;
  logic         out_valid;
  logic         out_stall = 1'b0;
  value_t       out_size_value;
  logic [1:0]   out_status;

  // bytes waiting to be offered, and parse results still owed by the block
  logic [7:0]   pending_bytes[$];
  size_result_t expected_sizes[$];

  int errors = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int gap_burst = 0;
  int stall_left = 0;
  int stall_burst = 0;
  int hold_left = 0;

  // shadow copy of the parser state
  phase_t phase_now;
  value_t acc_now;
  radix_t radix_now;
  bit     have_digit;
  bit     digits_overflowed;
  logic [3:0] power_now;
  bit     base_thousand;
  bit     bad_syntax;

  size_string_parser uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_size_value (out_size_value),
    .out_status     (out_status)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow parser: mirror what the block does with each accepted request.
  // ---------------------------------------------------------------------------

  task automatic clear_parser();
    phase_now = PH_IDLE;
    acc_now = '0;
    radix_now = RADIX_DEC;
    have_digit = 1'b0;
    digits_overflowed = 1'b0;
    power_now = '0;
    base_thousand = 1'b0;
    bad_syntax = 1'b0;
  endtask

  // digit value of c in radix r, or -1 when c is no digit there
  function automatic int digit_in_radix(logic [7:0] c, radix_t r);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    if (r == RADIX_OCT && d > 7) d = -1;
    if (r == RADIX_DEC && d > 9) d = -1;
    return d;
  endfunction

  // accumulate one digit; once the value no longer fits, keep eating digits
  task automatic push_digit(int d);
    value_t base;
    value_t dv;
    base = (radix_now == RADIX_OCT) ? 64'd8 : ((radix_now == RADIX_HEX) ? 64'd16 : 64'd10);
    dv = value_t'(d);
    have_digit = 1'b1;
    if (!digits_overflowed) begin
      if (acc_now > (SIZE_MAX - dv) / base) digits_overflowed = 1'b1;
      else acc_now = acc_now * base + dv;
    end
  endtask

  function automatic logic [3:0] suffix_power(logic [7:0] c);
    case (c)
      "K", "k": return 4'd1;
      "M", "m": return 4'd2;
      "G", "g": return 4'd3;
      "T", "t": return 4'd4;
      "P", "p": return 4'd5;
      "E", "e": return 4'd6;
      "Z":      return 4'd7;
      "Y":      return 4'd8;
      default:  return 4'd0;
    endcase
  endfunction

  task automatic take_suffix(logic [7:0] c);
    logic [3:0] p;
    p = suffix_power(c);
    if (p == 0) begin
      bad_syntax = 1'b1;
    end else begin
      power_now = p;
      phase_now = PH_LETTER;
    end
  endtask

  // terminator: scale the accumulated value and queue the result owed
  task automatic close_string();
    size_result_t res;
    value_t x;
    value_t base;
    res.size_value = '0;
    res.status = STAT_INVALID;
    if (!bad_syntax && have_digit && !digits_overflowed &&
        phase_now != PH_HEXPFX && phase_now != PH_SUF_I) begin
      res.status = STAT_OK;
      x = acc_now;
      base = base_thousand ? 64'd1000 : 64'd1024;
      if (phase_now == PH_LETTER || phase_now == PH_SUF_END) begin
        for (int i = 0; i < power_now; i++) begin
          if (res.status == STAT_OK) begin
            // stop at the last product that still fits
            if (SIZE_MAX / base < x) res.status = STAT_OVERFLOW;
            else x = x * base;
          end
        end
      end
      res.size_value = x;
    end
    expected_sizes.push_back(res);
    clear_parser();
  endtask

  task automatic parse_byte(logic [7:0] c);
    int d;
    if (c == 8'h00) begin
      close_string();
    end else if (!bad_syntax) begin
      case (phase_now)
        PH_IDLE, PH_SIGN: begin
          if (phase_now == PH_IDLE && (c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
            // skip leading whitespace
          end else if (phase_now == PH_IDLE && c == "+") begin
            phase_now = PH_SIGN;
          end else if (c == "0") begin
            have_digit = 1'b1;
            phase_now = PH_ZERO;
          end else if (c >= "1" && c <= "9") begin
            radix_now = RADIX_DEC;
            push_digit(c - "0");
            phase_now = PH_DIGITS;
          end else begin
            bad_syntax = 1'b1;
          end
        end
        PH_ZERO: begin
          if (c == "x" || c == "X") begin
            phase_now = PH_HEXPFX;
          end else if (c >= "0" && c <= "7") begin
            radix_now = RADIX_OCT;
            push_digit(c - "0");
            phase_now = PH_DIGITS;
          end else begin
            // a non-octal byte after a lone zero is read as a suffix letter
            take_suffix(c);
          end
        end
        PH_HEXPFX: begin
          d = digit_in_radix(c, RADIX_HEX);
          if (d < 0) begin
            bad_syntax = 1'b1;
          end else begin
            radix_now = RADIX_HEX;
            push_digit(d);
            phase_now = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          d = digit_in_radix(c, radix_now);
          if (d >= 0) push_digit(d);
          else take_suffix(c);
        end
        PH_LETTER: begin
          if (c == "i") begin
            phase_now = PH_SUF_I;
          end else if (c == "B") begin
            base_thousand = 1'b1;
            phase_now = PH_SUF_END;
          end else begin
            bad_syntax = 1'b1;
          end
        end
        PH_SUF_I: begin
          if (c == "B") phase_now = PH_SUF_END;
          else bad_syntax = 1'b1;
        end
        default: begin
          // anything after a complete suffix is an error
          bad_syntax = 1'b1;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // queue a whole string and its terminator
  task automatic add_string(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    pending_bytes.push_back(8'h00);
  endtask

  // mostly well-formed sizes with random content, some noise and broken ones
  task automatic add_random_string();
    string spaces;
    string hex_digits;
    string letters;
    string bad_letters;
    int    start;
    int    n;
    int    kind;
    int    tail;
    spaces = "\t\n\v\f\r ";
    hex_digits = "0123456789abcdefABCDEF";
    letters = "KMGTPEkmgtpeZY";
    bad_letters = "QzyXbi";
    start = pending_bytes.size();
    if ($urandom_range(0, 99) < 10) begin
      // pure noise
      n = $urandom_range(1, 8);
      repeat (n) pending_bytes.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 99) < 30) begin
        n = $urandom_range(1, 3);
        repeat (n) pending_bytes.push_back(spaces[$urandom_range(0, 5)]);
      end
      kind = $urandom_range(0, 99);
      if (kind < 15) pending_bytes.push_back("+");
      else if (kind < 18) pending_bytes.push_back("-");

      // short numbers mostly; long ones push the accumulator and the scaler over
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(12, 22);
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        pending_bytes.push_back(8'h31 + 8'($urandom_range(0, 8)));
        repeat (n) pending_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
      end else if (kind == 6) begin
        pending_bytes.push_back("0");
        repeat (n) pending_bytes.push_back(8'h30 + 8'($urandom_range(0, 7)));
      end else if (kind == 7) begin
        pending_bytes.push_back("0");
        pending_bytes.push_back($urandom_range(0, 1) ? "x" : "X");
        repeat (n) pending_bytes.push_back(hex_digits[$urandom_range(0, 21)]);
      end else if (kind == 8) begin
        pending_bytes.push_back("0");
      end

      kind = $urandom_range(0, 9);
      if (kind >= 3) begin
        if (kind == 9) pending_bytes.push_back(bad_letters[$urandom_range(0, 5)]);
        else pending_bytes.push_back(letters[$urandom_range(0, 13)]);
        tail = $urandom_range(0, 9);
        if (tail < 3) begin
          pending_bytes.push_back("i");
          pending_bytes.push_back("B");
        end else if (tail < 5) begin
          pending_bytes.push_back("B");
        end else if (tail == 5) begin
          pending_bytes.push_back("i");
        end else if (tail == 6) begin
          pending_bytes.push_back("B");
          pending_bytes.push_back(8'($urandom_range(1, 255)));
        end
      end
    end
    // now and then corrupt one byte of the string
    if (pending_bytes.size() > start && $urandom_range(0, 99) < 5) begin
      pending_bytes[$urandom_range(start, pending_bytes.size() - 1)] =
        8'($urandom_range(1, 255));
    end
    pending_bytes.push_back(8'h00);
  endtask

  // idle length: mostly none or short, a few long, and bursts with no idling
  function automatic int pick_idle(inout int burst);
    int r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one request at a time, hold it while stalled, idle at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_char_code <= 8'h00;
    end else begin
      offer = !in_valid;
      if (in_valid && !in_stall) begin
        parse_byte(in_char_code);
        offer = 1'b1;
      end
      if (offer) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_char_code <= pending_bytes.pop_front();
          gap_left = pick_idle(gap_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: check each accepted result against the oldest one owed, and
  // drive out_stall with random stalls plus two long hold-offs.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    size_result_t want;
    logic stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_sizes.size() == 0) begin
          $display("%0t: unexpected result size_value=%0d status=%0d",
                   $time, out_size_value, out_status);
          errors++;
        end else begin
          want = expected_sizes.pop_front();
          if (out_size_value !== want.size_value) begin
            $display("%0t: size_value mismatch expected=%0d actual=%0d",
                     $time, want.size_value, out_size_value);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, want.status, out_status);
            errors++;
          end
        end
        // hold off long enough for the block to fill and stall its input
        if (results_seen == 10 || results_seen == 100) hold_left = HOLD_CYCLES;
      end

      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else begin
        stall_left = pick_idle(stall_burst);
        stall_next = (stall_left != 0);
        if (stall_next) stall_left--;
      end
      out_stall <= stall_next;
    end
  end

  // watchdog: bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build all stimulus, release reset, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    int directed_bytes;
    clear_parser();

    // directed strings: field extremes, every radix and suffix, error paths
    add_string("");                        // empty string
    add_string(" \t\n\v\f\r ");            // blank string
    add_string("  \t42");
    add_string("+7");
    add_string("-3");
    add_string("0");
    add_string("0x");                      // hex prefix without digit
    add_string("0xfF");
    add_string("0X1aBk");
    add_string("017");
    add_string("08");                      // non-octal digit after leading zero
    add_string("0k");
    add_string("18446744073709551615");
    add_string("18446744073709551616");    // digit overflow
    add_string("0x1FFFFFFFFFFFFFFFF1");
    add_string("1KiB");
    add_string("3MB");
    add_string("5Gi");                     // i without B
    add_string("2TBx");                    // byte after complete suffix
    add_string("1Q");                      // unknown letter
    add_string("1Y");                      // scaling overflow
    add_string("1ZB");
    add_string("16E");
    add_string("9p");
    add_string("1z");
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(8'h00);
    add_string("1K\377");

    directed_bytes = pending_bytes.size();
    while (pending_bytes.size() - directed_bytes < RANDOM_BYTES) add_random_string();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every request to be taken and every result to come back
    while (pending_bytes.size() != 0 || in_valid || expected_sizes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
